// ----- rtl/frac_pkg.sv -----
// Shared constants and types for the freed-region access checker.
`default_nettype none
package frac_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned OPC_W    = 4;
  localparam int unsigned STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_SIZE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FREE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WRITE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_NONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UAF_READ  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UAF_WRITE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  localparam logic [OPC_W-1:0] OPERANDS_CHECKED = 4'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the item and the table compare results
    logic commit;   // update the table and issue the result
  } ctrl_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/frac_ctrl.sv -----
// Controller state machine for the freed-region access checker.
`default_nettype none
module frac_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output frac_pkg::ctrl_cmd_t     cmd
);

  typedef enum logic {
    S_IDLE,
    S_UPDATE
  } state_t;

  state_t state_r;
  logic   busy_r;

  always_comb begin
    cmd.capture = start && !busy_r;
    cmd.commit  = (state_r == S_UPDATE);
  end

  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_UPDATE;
            busy_r  <= 1'b1;
          end
        end
        S_UPDATE: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/frac_datapath.sv -----
// Region table, parallel compare lanes and result registers.
`default_nettype none
module frac_datapath #(
  parameter int unsigned TABLE_ENTRIES = frac_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire frac_pkg::ctrl_cmd_t             cmd,
  input  wire logic [frac_pkg::MODE_W-1:0]     in_mode,
  input  wire logic [frac_pkg::ADDR_W-1:0]     in_address,
  input  wire logic [frac_pkg::ADDR_W-1:0]     in_alloc_size,
  input  wire logic [frac_pkg::OPC_W-1:0]      in_operand_count,
  input  wire logic [frac_pkg::ADDR_W-1:0]     in_instr_address,
  output logic                                 out_valid,
  output logic [frac_pkg::STATUS_W-1:0]        out_status,
  output logic [frac_pkg::ADDR_W-1:0]          out_fault_address,
  output logic [frac_pkg::ADDR_W-1:0]          out_fault_instr
);

  localparam int unsigned AW = frac_pkg::ADDR_W;
  localparam int unsigned N  = TABLE_ENTRIES;

  // Region table; base and size are meaningful only while valid.
  logic [AW-1:0] base_r [N];
  logic [AW-1:0] size_r [N];
  logic [N-1:0]  freed_r;
  logic [N-1:0]  valid_r;
  logic [AW-1:0] pending_size_r;

  // Item captured for the update cycle.
  logic [frac_pkg::MODE_W-1:0] mode_r;
  logic [AW-1:0]               addr_r;
  logic [AW-1:0]               instr_r;
  logic                        opc_ok_r;
  logic [N-1:0]                hit_r;
  logic                        uaf_r;

  logic                          out_valid_r;
  logic [frac_pkg::STATUS_W-1:0] out_status_r;
  logic [AW-1:0]                 out_fault_address_r;
  logic [AW-1:0]                 out_fault_instr_r;

  logic [N-1:0] hit_nxt;
  logic [N-1:0] in_region;
  logic [N-1:0] free_oh;
  logic         full;
  logic         any_hit;
  logic         do_match;
  logic         do_insert;
  logic         do_free;

  // One compare lane per entry: base match and freed-range hit.
  always_comb begin
    for (int k = 0; k < N; k++) begin
      logic [AW-1:0] hi;
      hi           = base_r[k] + size_r[k];
      hit_nxt[k]   = valid_r[k] && (base_r[k] == in_address);
      in_region[k] = valid_r[k] && freed_r[k] &&
                     (in_address >= base_r[k]) && (in_address < hi);
    end
  end

  // Lowest empty slot as a one-hot vector.
  assign free_oh = ~valid_r & (valid_r + N'(1));
  assign full    = &valid_r;
  assign any_hit = |hit_r;

  assign do_match  = cmd.commit && (mode_r == frac_pkg::MODE_ALLOC) &&
                     (addr_r != '0) && any_hit;
  assign do_insert = cmd.commit && (mode_r == frac_pkg::MODE_ALLOC) &&
                     (addr_r != '0) && !any_hit && !full;
  assign do_free   = cmd.commit && (mode_r == frac_pkg::MODE_FREE);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r   <= in_mode;
      addr_r   <= in_address;
      instr_r  <= in_instr_address;
      opc_ok_r <= (in_operand_count == frac_pkg::OPERANDS_CHECKED);
      hit_r    <= hit_nxt;
      uaf_r    <= |in_region;
    end
  end

  // Table payload: written on re-arm or insert.
  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if ((do_match && hit_r[k]) || (do_insert && free_oh[k])) begin
        size_r[k] <= pending_size_r;
      end
      if (do_insert && free_oh[k]) begin
        base_r[k] <= addr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r        <= '0;
      freed_r        <= '0;
      pending_size_r <= '0;
    end else begin
      if (cmd.capture && (in_mode == frac_pkg::MODE_SIZE)) begin
        pending_size_r <= in_alloc_size;
      end
      for (int k = 0; k < N; k++) begin
        if ((do_match && hit_r[k]) || (do_insert && free_oh[k])) begin
          freed_r[k] <= 1'b0;
        end else if (do_free && hit_r[k]) begin
          freed_r[k] <= 1'b1;
        end
        if (do_insert && free_oh[k]) begin
          valid_r[k] <= 1'b1;
        end
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r        <= frac_pkg::ST_NONE;
      out_fault_address_r <= '0;
      out_fault_instr_r   <= '0;
      unique case (mode_r)
        frac_pkg::MODE_ALLOC: begin
          if ((addr_r != '0) && !any_hit && full) begin
            out_status_r        <= frac_pkg::ST_FULL;
            out_fault_address_r <= addr_r;
          end
        end
        frac_pkg::MODE_READ: begin
          if (opc_ok_r && uaf_r) begin
            out_status_r        <= frac_pkg::ST_UAF_READ;
            out_fault_address_r <= addr_r;
            out_fault_instr_r   <= instr_r;
          end
        end
        frac_pkg::MODE_WRITE: begin
          if (opc_ok_r && uaf_r) begin
            out_status_r        <= frac_pkg::ST_UAF_WRITE;
            out_fault_address_r <= addr_r;
            out_fault_instr_r   <= instr_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_fault_address = out_fault_address_r;
  assign out_fault_instr   = out_fault_instr_r;

endmodule
`default_nettype wire

// ----- rtl/freed_region_access_checker.sv -----
// Top level: tracks heap regions and flags accesses into freed ones.
// An accepted item is captured, then committed in S_UPDATE, and its result is registered.
// No new item during the update; compare lanes run in the accept cycle, table update next.
// busy is high during the update cycle; start is taken whenever busy is low.
// Reset (rst_n low, synchronous) empties the table and clears the pending size.
// The receiver cannot stall: out_valid marks each result for exactly one cycle.
`default_nettype none
module freed_region_access_checker #(
  parameter int unsigned TABLE_ENTRIES = frac_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [frac_pkg::MODE_W-1:0]     in_mode,
  input  wire logic [frac_pkg::ADDR_W-1:0]     in_address,
  input  wire logic [frac_pkg::ADDR_W-1:0]     in_alloc_size,
  input  wire logic [frac_pkg::OPC_W-1:0]      in_operand_count,
  input  wire logic [frac_pkg::ADDR_W-1:0]     in_instr_address,
  output logic                                 out_valid,
  output logic [frac_pkg::STATUS_W-1:0]        out_status,
  output logic [frac_pkg::ADDR_W-1:0]          out_fault_address,
  output logic [frac_pkg::ADDR_W-1:0]          out_fault_instr
);

  frac_pkg::ctrl_cmd_t cmd;

  // Sequence each item: capture on accept, then commit the table update.
  frac_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Hold the region table, compare all entries in parallel, drive the result.
  frac_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_mode           (in_mode),
    .in_address        (in_address),
    .in_alloc_size     (in_alloc_size),
    .in_operand_count  (in_operand_count),
    .in_instr_address  (in_instr_address),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_fault_address (out_fault_address),
    .out_fault_instr   (out_fault_instr)
  );

endmodule
`default_nettype wire
